[sv/battery_level_hysteresis_defines.svh]
// Assertion macros for the battery level hysteresis block.
// No dependencies; included by the top level.
`ifndef BATTERY_LEVEL_HYSTERESIS_DEFINES_SVH
`define BATTERY_LEVEL_HYSTERESIS_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define BLH_ASSERT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed");
`define BLH_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed");
`else
`define BLH_ASSERT(lbl, clk, rst, ante, cons)
`define BLH_ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

[sv/blh_pkg.sv]
// Types, constants and helpers for the battery level hysteresis block.
// No dependencies.
package blh_pkg;

  localparam int unsigned VOLT_W = 10;
  localparam int unsigned CNT_W  = 16;
  localparam int unsigned LVL_W  = 3;
  localparam int unsigned IDX_W  = 3;

  localparam logic [LVL_W-1:0] LVL_MAX = 3'd5;

  localparam logic [CNT_W-1:0] RISE_HOLD    = 16'd3000;
  localparam logic [CNT_W-1:0] FALL_HOLD    = 16'd3000;
  localparam logic [CNT_W-1:0] FALL_HOLD_L1 = 16'd10000;
  localparam logic [CNT_W-1:0] FALL_HOLD_L5 = 16'd7000;

  localparam logic [VOLT_W-1:0] RST_T20  = 10'd360;
  localparam logic [VOLT_W-1:0] RST_T40  = 10'd370;
  localparam logic [VOLT_W-1:0] RST_T60  = 10'd380;
  localparam logic [VOLT_W-1:0] RST_T80  = 10'd400;
  localparam logic [VOLT_W-1:0] RST_T100 = 10'd410;
  localparam logic [VOLT_W-1:0] RST_STEP = 10'd10;

  typedef enum logic {
    CMD_TICK = 1'b0,
    CMD_SEED = 1'b1
  } cmd_t;

  typedef enum logic [IDX_W-1:0] {
    REG_T20  = 3'd0,
    REG_T40  = 3'd1,
    REG_T60  = 3'd2,
    REG_T80  = 3'd3,
    REG_T100 = 3'd4,
    REG_STEP = 3'd5
  } reg_idx_t;

  // saturating hold counter increment
  function automatic logic [CNT_W-1:0] sat_add(input logic [CNT_W-1:0] c,
                                               input logic [VOLT_W-1:0] s);
    logic [CNT_W:0] sum;
    sum = {1'b0, c} + {{(CNT_W+1-VOLT_W){1'b0}}, s};
    return sum[CNT_W] ? {CNT_W{1'b1}} : sum[CNT_W-1:0];
  endfunction

endpackage

[sv/battery_level_hysteresis.sv]
// Battery level hysteresis: six-step level from voltage samples.
// Uses blh_pkg and battery_level_hysteresis_defines.svh.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one word per sample: command,
//   battery_voltage, charging. Command tick updates the level with hold
//   counters; command seed sets the level straight from the thresholds.
//   Output channel (out_valid/out_ready) returns one word per input: level.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes the
//   five thresholds and the tick step; cfg_ready is always high and writes
//   to indexes above 5 are dropped. Write config only while idle.
//   Path: the input register, then the update into the result register.
//   Throughput: one word per cycle while the output is not stalled, set by
//   the level/counter update loop.
//   Reset: level and counters clear, thresholds return to defaults, both
//   channels empty.
//   Output stall: the result register holds; one more input word is taken
//   into the input register, then in_ready drops until out_ready returns.
`include "battery_level_hysteresis_defines.svh"

module battery_level_hysteresis
  import blh_pkg::*;
(
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_ready,
  input  logic              command,
  input  logic [VOLT_W-1:0] battery_voltage,
  input  logic              charging,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [LVL_W-1:0]  level,
  input  logic              cfg_valid,
  output logic              cfg_ready,
  input  logic [IDX_W-1:0]  cfg_index,
  input  logic [VOLT_W-1:0] cfg_data
);

  logic [VOLT_W-1:0] thresh_20, thresh_40, thresh_60, thresh_80, thresh_100;
  logic [VOLT_W-1:0] tick_step;

  logic              s1_valid;
  cmd_t              s1_command;
  logic [VOLT_W-1:0] s1_voltage;
  logic              s1_charging;

  logic [LVL_W-1:0]  cur_level, cur_level_next;
  logic [CNT_W-1:0]  high_hold, high_hold_next;
  logic [CNT_W-1:0]  low_hold, low_hold_next;

  logic              advance;
  logic [CNT_W-1:0]  hh_inc, lh_inc;
  logic [VOLT_W-1:0] thr_up, thr_cur;
  logic [LVL_W-1:0]  seed_level;
  logic [CNT_W-1:0]  fall_hold;

  function automatic logic [VOLT_W-1:0] thr(input logic [LVL_W-1:0] n,
                                            input logic [VOLT_W-1:0] t1,
                                            input logic [VOLT_W-1:0] t2,
                                            input logic [VOLT_W-1:0] t3,
                                            input logic [VOLT_W-1:0] t4,
                                            input logic [VOLT_W-1:0] t5);
    logic [VOLT_W-1:0] r;
    case (n)
      3'd1:    r = t1;
      3'd2:    r = t2;
      3'd3:    r = t3;
      3'd4:    r = t4;
      default: r = t5;
    endcase
    return r;
  endfunction

  assign cfg_ready = 1'b1;
  assign advance   = s1_valid && (!out_valid || out_ready);
  assign in_ready  = !s1_valid || advance;

  always_ff @(posedge clk) begin
    if (rst) begin
      thresh_20  <= RST_T20;
      thresh_40  <= RST_T40;
      thresh_60  <= RST_T60;
      thresh_80  <= RST_T80;
      thresh_100 <= RST_T100;
      tick_step  <= RST_STEP;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_T20:  thresh_20  <= cfg_data;
        REG_T40:  thresh_40  <= cfg_data;
        REG_T60:  thresh_60  <= cfg_data;
        REG_T80:  thresh_80  <= cfg_data;
        REG_T100: thresh_100 <= cfg_data;
        REG_STEP: tick_step  <= cfg_data;
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_ready) begin
      s1_valid <= in_valid;
    end
    if (in_valid && in_ready) begin
      s1_command  <= cmd_t'(command);
      s1_voltage  <= battery_voltage;
      s1_charging <= charging;
    end
  end

  assign hh_inc    = sat_add(high_hold, tick_step);
  assign lh_inc    = sat_add(low_hold, tick_step);
  assign thr_up    = thr(cur_level + 3'd1, thresh_20, thresh_40, thresh_60,
                         thresh_80, thresh_100);
  assign thr_cur   = thr(cur_level, thresh_20, thresh_40, thresh_60,
                         thresh_80, thresh_100);
  assign fall_hold = (cur_level == 3'd1) ? FALL_HOLD_L1 : FALL_HOLD;

  always_comb begin
    if (s1_voltage >= thresh_100)     seed_level = 3'd5;
    else if (s1_voltage >= thresh_80) seed_level = 3'd4;
    else if (s1_voltage >= thresh_60) seed_level = 3'd3;
    else if (s1_voltage >= thresh_40) seed_level = 3'd2;
    else if (s1_voltage >= thresh_20) seed_level = 3'd1;
    else                              seed_level = 3'd0;
  end

  always_comb begin
    cur_level_next = cur_level;
    high_hold_next = high_hold;
    low_hold_next  = low_hold;
    if (s1_command == CMD_SEED) begin
      cur_level_next = seed_level;
    end else begin
      case (cur_level) inside
        3'd0: begin
          high_hold_next = (s1_voltage >= thresh_20) ? hh_inc : '0;
          if (s1_charging && high_hold_next >= RISE_HOLD) begin
            cur_level_next = 3'd1;
            high_hold_next = '0;
            low_hold_next  = '0;
          end
        end
        [3'd1:3'd4]: begin
          if (s1_voltage >= thr_up) begin
            high_hold_next = hh_inc;
            low_hold_next  = '0;
          end else if (s1_voltage < thr_cur) begin
            high_hold_next = '0;
            low_hold_next  = lh_inc;
          end else begin
            high_hold_next = '0;
            if (cur_level != 3'd2) low_hold_next = '0;
          end
          if (s1_charging && high_hold_next >= RISE_HOLD) begin
            cur_level_next = cur_level + 3'd1;
            high_hold_next = '0;
            low_hold_next  = '0;
          end
          if (!s1_charging && low_hold_next >= fall_hold) begin
            cur_level_next = cur_level - 3'd1;
            high_hold_next = '0;
            low_hold_next  = '0;
          end
        end
        LVL_MAX: begin
          low_hold_next = (s1_voltage < thresh_100) ? lh_inc : '0;
          if (low_hold_next >= FALL_HOLD_L5) begin
            cur_level_next = 3'd4;
            low_hold_next  = '0;
          end
        end
        default: ;
      endcase
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (rst) begin
      cur_level <= '0;
      high_hold <= '0;
      low_hold  <= '0;
      out_valid <= 1'b0;
    end else begin
      if (advance) begin
        cur_level <= cur_level_next;
        high_hold <= high_hold_next;
        low_hold  <= low_hold_next;
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
    if (advance) begin
      level <= cur_level_next;
    end
  end

  `BLH_ASSERT(a_level_range, clk, rst, 1'b1, cur_level <= LVL_MAX)
  `BLH_ASSERT_NEXT(a_result_matches_state, clk, rst, advance && !rst, out_valid && level == cur_level)
  `BLH_ASSERT_NEXT(a_seed_keeps_counters, clk, rst, advance && !rst && s1_command == CMD_SEED, $stable(high_hold) && $stable(low_hold))
  `BLH_ASSERT_NEXT(a_tick_one_step, clk, rst, advance && !rst && s1_command == CMD_TICK, (cur_level == $past(cur_level)) || (cur_level == $past(cur_level) + 3'd1) || (cur_level == $past(cur_level) - 3'd1))

endmodule

[bench/tb_top.sv]
`timescale 1ns / 100ps
// Self-checking bench for battery_level_hysteresis: directed and random sample words,
// checked against a level/hold-counter predictor, with random stalls on both data channels.
// Depends on blh_pkg and the battery_level_hysteresis RTL.
module tb_top;
  import blh_pkg::*;

  localparam int unsigned WATCHDOG_LIMIT = 4000;
  localparam int unsigned RX_HOLD_CYCLES = 200;
  localparam int unsigned DRAIN_SLACK    = 4;
  localparam logic [CNT_W-1:0] HOLD_CAP  = '1;
  localparam logic [IDX_W-1:0] REG_SPARE_6 = 3'd6;
  localparam logic [IDX_W-1:0] REG_SPARE_7 = 3'd7;

  logic              clk = 1'b0;
  logic              rst = 1'b1;
  logic              in_valid = 1'b0;
  logic              in_ready;
  logic              command = 1'b0;
  logic [VOLT_W-1:0] battery_voltage = '0;
  logic              charging = 1'b0;
  logic              out_valid;
  logic              out_ready = 1'b0;
  logic [LVL_W-1:0]  level;
  logic              cfg_valid = 1'b0;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index = '0;
  logic [VOLT_W-1:0] cfg_data = '0;

  // predictor state
  logic [VOLT_W-1:0] lvl_thr [1:5];
  logic [VOLT_W-1:0] tick_amt;
  logic [LVL_W-1:0]  model_level;
  logic [CNT_W-1:0]  rise_cnt;
  logic [CNT_W-1:0]  fall_cnt;
  logic [LVL_W-1:0]  pending_levels [$];
  logic [LVL_W-1:0]  due_level;

  int errors = 0;
  int samples = 0;
  int seeds = 0;
  int checked = 0;
  int cfg_writes = 0;
  int idle_cycles = 0;
  logic [5:0] levels_seen = '0;

  logic tx_gaps_on = 1'b1;
  logic rx_stalls_on = 1'b1;
  logic rx_hold_req = 1'b0;

  battery_level_hysteresis dut (
    .clk             (clk),
    .rst             (rst),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .command         (command),
    .battery_voltage (battery_voltage),
    .charging        (charging),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .level           (level),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  function automatic logic [CNT_W-1:0] hold_plus(input logic [CNT_W-1:0] c);
    logic [CNT_W:0] s;
    s = c + tick_amt;
    return (s > {1'b0, HOLD_CAP}) ? HOLD_CAP : s[CNT_W-1:0];
  endfunction

  function automatic void update_level_model(input logic cmd, input logic [VOLT_W-1:0] v,
                                             input logic chg);
    int lv;
    lv = int'(model_level);
    if (cmd == CMD_SEED) begin
      model_level = '0;
      for (int k = 1; k <= 5; k++) begin
        if (v >= lvl_thr[k]) model_level = k[LVL_W-1:0];
      end
    end else if (lv == 0) begin
      rise_cnt = (v >= lvl_thr[1]) ? hold_plus(rise_cnt) : '0;
      if (chg && rise_cnt >= RISE_HOLD) begin
        model_level = 3'd1;
        rise_cnt = '0;
        fall_cnt = '0;
      end
    end else if (lv <= 4) begin
      if (v >= lvl_thr[lv + 1]) begin
        rise_cnt = hold_plus(rise_cnt);
        fall_cnt = '0;
      end else if (v < lvl_thr[lv]) begin
        rise_cnt = '0;
        fall_cnt = hold_plus(fall_cnt);
      end else begin
        rise_cnt = '0;
        // level 2 keeps its fall count through the dead band
        if (lv != 2) fall_cnt = '0;
      end
      if (chg && rise_cnt >= RISE_HOLD) begin
        model_level = model_level + 1'b1;
        rise_cnt = '0;
        fall_cnt = '0;
      end
      if (!chg && fall_cnt >= ((lv == 1) ? FALL_HOLD_L1 : FALL_HOLD)) begin
        model_level = model_level - 1'b1;
        rise_cnt = '0;
        fall_cnt = '0;
      end
    end else if (lv == 5) begin
      fall_cnt = (v < lvl_thr[5]) ? hold_plus(fall_cnt) : '0;
      if (fall_cnt >= FALL_HOLD_L5) begin
        model_level = 3'd4;
        fall_cnt = '0;
      end
    end
  endfunction

  // predictor and checker, all at the rising edge
  always @(posedge clk) begin
    if (rst) begin
      lvl_thr[1] = RST_T20;
      lvl_thr[2] = RST_T40;
      lvl_thr[3] = RST_T60;
      lvl_thr[4] = RST_T80;
      lvl_thr[5] = RST_T100;
      tick_amt = RST_STEP;
      model_level = '0;
      rise_cnt = '0;
      fall_cnt = '0;
      pending_levels.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_T20:  lvl_thr[1] = cfg_data;
          REG_T40:  lvl_thr[2] = cfg_data;
          REG_T60:  lvl_thr[3] = cfg_data;
          REG_T80:  lvl_thr[4] = cfg_data;
          REG_T100: lvl_thr[5] = cfg_data;
          REG_STEP: tick_amt = cfg_data;
          default: ;
        endcase
        cfg_writes++;
      end
      if (in_valid && in_ready) begin
        update_level_model(command, battery_voltage, charging);
        pending_levels.push_back(model_level);
        levels_seen[model_level] = 1'b1;
        samples++;
        if (command == CMD_SEED) seeds++;
      end
      if (out_valid && out_ready) begin
        if (pending_levels.size() == 0) begin
          errors++;
          $error("unexpected level word %0d with nothing pending", level);
        end else begin
          due_level = pending_levels.pop_front();
          checked++;
          if (level !== due_level) begin
            errors++;
            $error("level mismatch: expected %0d, actual %0d", due_level, level);
          end
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("watchdog: no handshake for %0d cycles, %0d words pending",
               idle_cycles, pending_levels.size());
      $display("*** FAILED ***");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // receiver side: random stalls, plus one long hold-off on request
  initial begin : rx_side
    int stall;
    stall = 0;
    forever begin
      @(negedge clk);
      if (rst) begin
        out_ready <= 1'b0;
      end else if (stall > 0) begin
        out_ready <= 1'b0;
        stall--;
      end else if (rx_hold_req) begin
        rx_hold_req = 1'b0;
        stall = RX_HOLD_CYCLES - 1;
        out_ready <= 1'b0;
      end else begin
        stall = rx_stalls_on ? pick_gap() : 0;
        if (stall > 0) begin
          out_ready <= 1'b0;
          stall--;
        end else begin
          out_ready <= 1'b1;
        end
      end
    end
  end

  // all driver tasks start and end just after a falling edge
  task automatic send_word(input cmd_t cmd, input logic [VOLT_W-1:0] v, input logic chg);
    int gap;
    gap = tx_gaps_on ? pick_gap() : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    battery_voltage <= v;
    charging <= chg;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    @(negedge clk);
  endtask

  task automatic wait_drain();
    in_valid <= 1'b0;
    while (pending_levels.size() != 0) @(negedge clk);
    repeat (DRAIN_SLACK) @(negedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [VOLT_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task automatic set_config(input logic [VOLT_W-1:0] t1, input logic [VOLT_W-1:0] t2,
                            input logic [VOLT_W-1:0] t3, input logic [VOLT_W-1:0] t4,
                            input logic [VOLT_W-1:0] t5, input logic [VOLT_W-1:0] step);
    wait_drain();
    write_reg(REG_T20, t1);
    write_reg(REG_T40, t2);
    write_reg(REG_T60, t3);
    write_reg(REG_T80, t4);
    write_reg(REG_T100, t5);
    write_reg(REG_STEP, step);
  endtask

  // voltage inside band b: between T(b) and T(b+1), often right at an edge
  function automatic logic [VOLT_W-1:0] band_voltage(input int b);
    int lo;
    int hi;
    int r;
    if (b == 0) lo = 0;
    else lo = int'(lvl_thr[b]);
    if (b == 5) hi = 1023;
    else hi = int'(lvl_thr[b + 1]) - 1;
    if (hi < lo) hi = lo;
    r = $urandom_range(0, 3);
    if (r == 0 && hi > lo + 2) hi = lo + 2;
    else if (r == 1 && hi > lo + 2) lo = hi - 2;
    return VOLT_W'(lo + int'($urandom_range(0, hi - lo)));
  endfunction

  // runs of ticks that sit in one voltage band, with seeds and noise mixed in
  task automatic run_traffic(input int n);
    int sent;
    int run_len;
    int b;
    int r;
    logic chg;
    sent = 0;
    while (sent < n) begin
      b = $urandom_range(0, 5);
      chg = 1'($urandom_range(0, 1));
      run_len = ($urandom_range(0, 9) < 3) ? $urandom_range(15, 40) : $urandom_range(1, 12);
      for (int i = 0; i < run_len && sent < n; i++) begin
        r = $urandom_range(0, 99);
        if (r < 8) begin
          send_word(CMD_SEED, band_voltage($urandom_range(0, 5)), 1'($urandom_range(0, 1)));
        end else if (r < 15) begin
          send_word(CMD_TICK, VOLT_W'($urandom_range(0, 1023)), 1'($urandom_range(0, 1)));
        end else begin
          if ($urandom_range(0, 19) == 0) chg = ~chg;
          send_word(CMD_TICK, band_voltage(b), chg);
        end
        sent++;
      end
    end
  endtask

  task automatic random_config();
    logic [VOLT_W-1:0] t [1:5];
    logic [VOLT_W-1:0] step;
    int base;
    int inc;
    case ($urandom_range(0, 3))
      0: begin
        base = $urandom_range(0, 950);
        inc = 20;
      end
      1: begin
        base = $urandom_range(0, 200);
        inc = 150;
      end
      default: begin
        base = -1;
        inc = 0;
      end
    endcase
    for (int k = 1; k <= 5; k++) begin
      if (base < 0) begin
        t[k] = VOLT_W'($urandom_range(0, 1023));
      end else begin
        t[k] = (base > 1023) ? 10'd1023 : base[VOLT_W-1:0];
        base = base + $urandom_range(0, inc);
      end
    end
    case ($urandom_range(0, 9))
      0: step = 10'd1000;
      1: step = 10'd1023;
      2, 3: step = VOLT_W'($urandom_range(1, 299));
      default: step = VOLT_W'($urandom_range(300, 1023));
    endcase
    set_config(t[1], t[2], t[3], t[4], t[5], step);
  endtask

  task automatic test_directed();
    // seeds just below and at the lowest default threshold, at each of the others, and the voltage extremes
    send_word(CMD_SEED, RST_T20 - 10'd1, 1'b0);
    send_word(CMD_SEED, RST_T20, 1'b1);
    send_word(CMD_SEED, RST_T40, 1'b0);
    send_word(CMD_SEED, RST_T60, 1'b1);
    send_word(CMD_SEED, RST_T80, 1'b0);
    send_word(CMD_SEED, RST_T100, 1'b1);
    send_word(CMD_SEED, 10'd1023, 1'b0);
    send_word(CMD_SEED, 10'd0, 1'b1);
    send_word(CMD_TICK, 10'd1023, 1'b0);
    send_word(CMD_TICK, 10'd0, 1'b1);
    send_word(CMD_TICK, 10'd1023, 1'b1);
    send_word(CMD_TICK, 10'd0, 1'b0);
    set_config(RST_T20, RST_T40, RST_T60, RST_T80, RST_T100, 10'd1023);
    repeat (3) send_word(CMD_TICK, 10'd1023, 1'b1);
    // full battery drops to 4 even while charging
    send_word(CMD_SEED, 10'd1023, 1'b0);
    repeat (7) send_word(CMD_TICK, 10'd0, 1'b1);
  endtask

  task automatic test_saturation();
    set_config(RST_T20, RST_T40, RST_T60, RST_T80, RST_T100, 10'd1023);
    send_word(CMD_SEED, 10'd0, 1'b0);
    repeat (70) send_word(CMD_TICK, 10'd1023, 1'b0);
    send_word(CMD_TICK, 10'd1023, 1'b1);
    repeat (70) send_word(CMD_TICK, 10'd0, 1'b1);
    send_word(CMD_TICK, 10'd0, 1'b0);
  endtask

  task automatic test_threshold_order();
    set_config(10'd1023, 10'd0, 10'd512, 10'd1, 10'd1022, 10'd500);
    run_traffic(60);
    set_config(10'd0, 10'd0, 10'd0, 10'd0, 10'd0, 10'd700);
    run_traffic(20);
    set_config(10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1023, 10'd1000);
    run_traffic(20);
  endtask

  task automatic test_zero_step();
    set_config(RST_T20, RST_T40, RST_T60, RST_T80, RST_T100, 10'd0);
    run_traffic(40);
  endtask

  task automatic test_spare_index();
    wait_drain();
    write_reg(REG_SPARE_6, VOLT_W'($urandom_range(0, 1023)));
    write_reg(REG_SPARE_7, VOLT_W'($urandom_range(0, 1023)));
    run_traffic(20);
  endtask

  task automatic test_backpressure();
    set_config(RST_T20, RST_T40, RST_T60, RST_T80, RST_T100, 10'd800);
    tx_gaps_on = 1'b0;
    rx_stalls_on = 1'b0;
    rx_hold_req = 1'b1;
    run_traffic(30);
    wait_drain();
    run_traffic(10);
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  task automatic test_random_phases();
    for (int p = 0; p < 8; p++) begin
      random_config();
      tx_gaps_on = ($urandom_range(0, 3) != 0);
      rx_stalls_on = ($urandom_range(0, 3) != 0);
      run_traffic(75);
    end
    tx_gaps_on = 1'b1;
    rx_stalls_on = 1'b1;
  endtask

  initial begin
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;
    test_directed();
    test_saturation();
    test_threshold_order();
    test_zero_step();
    test_spare_index();
    test_backpressure();
    test_random_phases();
    wait_drain();
    $display("Checked %0d level words from %0d samples (%0d seeds), %0d register writes.",
             checked, samples, seeds, cfg_writes);
    $display("Levels reached (bit per level 5..0): %b", levels_seen);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule

[filelist.f]
+incdir+sv
sv/blh_pkg.sv
sv/battery_level_hysteresis.sv
bench/tb_top.sv
